/* design/serial_packet_deframer_core_defines.svh */
// ----------------------------------------------------------------------------
// serial packet deframer assertion macros
// shared property forms used by the deframer top level checks
// ----------------------------------------------------------------------------
`ifndef SERIAL_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define SERIAL_PACKET_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication, checks off while reset is high
`define SPD_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");

// next-cycle implication, checks off while reset is high
`define SPD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

/* design/spd_pkg.sv */
// ----------------------------------------------------------------------------
// spd_pkg
// types and codes shared by the serial packet deframer modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

   // operation codes of a request word
   localparam logic [1:0] OP_RX_BYTE   = 2'd0;
   localparam logic [1:0] OP_HANDLED   = 2'd1;
   localparam logic [1:0] OP_READ_DATA = 2'd2;

   // reported frame state codes
   localparam logic [2:0] FS_HUNT     = 3'd0;
   localparam logic [2:0] FS_LENGTH   = 3'd1;
   localparam logic [2:0] FS_COMMAND  = 3'd2;
   localparam logic [2:0] FS_DATA     = 3'd3;
   localparam logic [2:0] FS_CHECKSUM = 3'd4;
   localparam logic [2:0] FS_END      = 3'd5;
   localparam logic [2:0] FS_BUSY     = 3'd6;

   // bytes of a frame that are not data: start, length, command, checksum, end
   localparam logic [8:0] HEADER_TRAILER_BYTES = 9'd5;

   // control register indexes
   localparam logic CSR_START_BYTE = 1'b0;
   localparam logic CSR_END_BYTE   = 1'b1;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
      logic [4:0] read_index;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] frame_state;
      logic       packet_ready;
      logic [7:0] packet_length;
      logic [7:0] command;
      logic [7:0] checksum;
      logic [5:0] data_count;
      logic       overflow;
   } frame_status_type;

   typedef struct packed {
      logic [2:0] frame_state;
      logic       packet_ready;
      logic [7:0] packet_length;
      logic [7:0] command;
      logic [7:0] checksum;
      logic [5:0] data_count;
      logic       overflow;
      logic [7:0] read_data;
   } rsp_payload_type;

   // data store write request from the frame fsm
   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } store_wr_type;

endpackage

`default_nettype wire

/* design/spd_stream_if.sv */
// ----------------------------------------------------------------------------
// spd_stream_if
// valid/ready stream channel carrying one payload word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spd_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

/* design/spd_frame_fsm.sv */
// ----------------------------------------------------------------------------
// spd_frame_fsm
// frame hunting state machine, header capture and data index tracking
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spd_frame_fsm #(
   parameter int STORE_DEPTH = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  spd_pkg::req_payload_type       req,
   input  wire logic [7:0]                start_byte,
   input  wire logic [7:0]                end_byte,
   output spd_pkg::frame_status_type      status,
   output spd_pkg::store_wr_type          store_wr
);
   import spd_pkg::*;

   localparam logic [7:0] DEPTH_BYTE = 8'(STORE_DEPTH);

   typedef enum logic [2:0] {
      ST_HUNT     = FS_HUNT,
      ST_LENGTH   = FS_LENGTH,
      ST_COMMAND  = FS_COMMAND,
      ST_DATA     = FS_DATA,
      ST_CHECKSUM = FS_CHECKSUM,
      ST_END      = FS_END,
      ST_BUSY     = FS_BUSY
   } state_type;

   state_type  state_ff, state_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] command_ff, command_in;
   logic [7:0] checksum_ff, checksum_in;
   logic [7:0] index_ff, index_in;
   logic       overflow_ff, overflow_in;
   logic [7:0] index_inc;
   logic [7:0] count;

   // data index saturates at the top of its byte range
   assign index_inc = (index_ff != 8'hff) ? index_ff + 8'd1 : index_ff;

   // next state for one accepted word
   always_comb begin
      state_in    = state_ff;
      length_in   = length_ff;
      command_in  = command_ff;
      checksum_in = checksum_ff;
      index_in    = index_ff;
      overflow_in = overflow_ff;
      store_wr    = '0;
      if (accept) begin
         unique case (req.op)
            OP_RX_BYTE: begin
               unique case (state_ff)
                  ST_HUNT: begin
                     if (req.rx_byte == start_byte) begin
                        index_in    = 8'd0;
                        overflow_in = 1'b0;
                        state_in    = ST_LENGTH;
                     end
                  end
                  ST_LENGTH: begin
                     length_in = req.rx_byte;
                     state_in  = ST_COMMAND;
                  end
                  ST_COMMAND: begin
                     command_in = req.rx_byte;
                     state_in   = ({1'b0, length_ff} > HEADER_TRAILER_BYTES) ?
                                  ST_DATA : ST_CHECKSUM;
                  end
                  ST_DATA: begin
                     // bytes past the store are counted but dropped
                     if (index_ff < DEPTH_BYTE) begin
                        store_wr.en   = 1'b1;
                        store_wr.addr = index_ff;
                        store_wr.data = req.rx_byte;
                     end else begin
                        overflow_in = 1'b1;
                     end
                     index_in = index_inc;
                     if ({1'b0, length_ff} <= {1'b0, index_inc} + HEADER_TRAILER_BYTES) begin
                        state_in = ST_CHECKSUM;
                     end
                  end
                  ST_CHECKSUM: begin
                     checksum_in = req.rx_byte;
                     state_in    = ST_END;
                  end
                  ST_END: begin
                     state_in = (req.rx_byte == end_byte) ? ST_BUSY : ST_HUNT;
                  end
                  ST_BUSY: begin
                     state_in = ST_BUSY;
                  end
                  default: begin
                     state_in = ST_HUNT;
                  end
               endcase
            end
            OP_HANDLED: begin
               state_in = ST_HUNT;
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   // state and captured header fields
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_HUNT;
         length_ff   <= 8'd0;
         command_ff  <= 8'd0;
         checksum_ff <= 8'd0;
         index_ff    <= 8'd0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         length_ff   <= length_in;
         command_ff  <= command_in;
         checksum_ff <= checksum_in;
         index_ff    <= index_in;
         overflow_ff <= overflow_in;
      end
   end

   // status as seen after the last accepted word
   assign count = (index_ff > DEPTH_BYTE) ? DEPTH_BYTE : index_ff;

   assign status.frame_state   = state_ff;
   assign status.packet_ready  = (state_ff == ST_BUSY);
   assign status.packet_length = length_ff;
   assign status.command       = command_ff;
   assign status.checksum      = checksum_ff;
   assign status.data_count    = count[5:0];
   assign status.overflow      = overflow_ff;

endmodule

`default_nettype wire

/* design/spd_data_store.sv */
// ----------------------------------------------------------------------------
// spd_data_store
// frame data memory with one write port and a registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spd_data_store #(
   parameter int STORE_DEPTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  spd_pkg::store_wr_type     store_wr,
   input  wire logic                 accept,
   input  wire logic                 read_req,
   input  wire logic [4:0]           read_index,
   output logic [7:0]                read_data
);
   import spd_pkg::*;

   localparam int         ADDR_W     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam logic [7:0] DEPTH_BYTE = 8'(STORE_DEPTH);

   logic [7:0]        mem [STORE_DEPTH];
   logic [ADDR_W-1:0] rd_addr;
   logic              in_range;
   logic              rd_hit;
   logic [7:0]        rd_data_ff;
   logic              rd_sel_ff;

   assign rd_addr  = ADDR_W'(read_index);
   assign in_range = (8'(read_index) < DEPTH_BYTE);
   assign rd_hit   = accept && read_req && in_range;

   // write port
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         mem[store_wr.addr[ADDR_W-1:0]] <= store_wr.data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_hit) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // marks whether the last word asked for a valid read
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_sel_ff <= 1'b0;
      end else if (accept) begin
         rd_sel_ff <= rd_hit;
      end
   end

   assign read_data = rd_sel_ff ? rd_data_ff : 8'd0;

endmodule

`default_nettype wire

/* design/spd_rsp_skid.sv */
// ----------------------------------------------------------------------------
// spd_rsp_skid
// result register tracking plus output skid register on the response side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spd_rsp_skid (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  spd_pkg::rsp_payload_type  result,
   output logic                      in_ready,
   output logic                      result_valid,
   spd_stream_if.source              rsp_ch
);
   import spd_pkg::*;

   logic            res_v_ff, res_v_in;
   logic            out_v_ff, out_v_in;
   rsp_payload_type out_ff;
   logic            move;

   // result word moves on when the output register is free or draining
   assign move     = res_v_ff && (!out_v_ff || rsp_ch.ready);
   assign in_ready = !res_v_ff || !out_v_ff || rsp_ch.ready;
   assign res_v_in = accept || (res_v_ff && !move);
   assign out_v_in = move || (out_v_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         res_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         res_v_ff <= res_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (move) begin
         out_ff <= result;
      end
   end

   assign result_valid   = res_v_ff;
   assign rsp_ch.valid   = out_v_ff;
   assign rsp_ch.payload = out_ff;

endmodule

`default_nettype wire

/* design/serial_packet_deframer_core.sv */
// ----------------------------------------------------------------------------
// serial_packet_deframer_core
// receives serial bytes and deframes start/length/command/data/checksum/end
// packets into header fields and a readable data store
// ----------------------------------------------------------------------------
//  channel   direction  handshake          word
//  req_ch    in         valid/ready        op, rx_byte, read_index
//  rsp_ch    out        valid/ready        status fields and read_data
//  csr_*     in         write enable only  register index and byte
//
//  one request word is taken every cycle while the response side keeps up
//  a response word passes the frame state and memory read register, then
//  the output register
//  the result and output registers give two words of slack, so a request is
//  still taken while one response waits
//  reset is synchronous; the data store has no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "serial_packet_deframer_core_defines.svh"

module serial_packet_deframer_core #(
   parameter int STORE_DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   spd_stream_if.sink       req_ch,
   spd_stream_if.source     rsp_ch,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wr_data
);
   import spd_pkg::*;

   logic [7:0]       start_byte_ff;
   logic [7:0]       end_byte_ff;
   logic             accept;
   logic             in_ready;
   logic             result_valid;
   frame_status_type status;
   store_wr_type     store_wr;
   logic [7:0]       read_data;
   rsp_payload_type  result;
   req_payload_type  req;

   assign req    = req_ch.payload;
   assign accept = req_ch.valid && in_ready;
   assign req_ch.ready = in_ready;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= 8'd2;
         end_byte_ff   <= 8'd3;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_BYTE: start_byte_ff <= csr_wr_data;
            CSR_END_BYTE:   end_byte_ff   <= csr_wr_data;
            default:        start_byte_ff <= start_byte_ff;
         endcase
      end
   end

   spd_frame_fsm #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_fsm (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req),
      .start_byte (start_byte_ff),
      .end_byte   (end_byte_ff),
      .status     (status),
      .store_wr   (store_wr)
   );

   spd_data_store #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .store_wr   (store_wr),
      .accept     (accept),
      .read_req   (req.op == OP_READ_DATA),
      .read_index (req.read_index),
      .read_data  (read_data)
   );

   // result word assembled from the state and read registers
   assign result.frame_state   = status.frame_state;
   assign result.packet_ready  = status.packet_ready;
   assign result.packet_length = status.packet_length;
   assign result.command       = status.command;
   assign result.checksum      = status.checksum;
   assign result.data_count    = status.data_count;
   assign result.overflow      = status.overflow;
   assign result.read_data     = read_data;

   spd_rsp_skid u_skid (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .result       (result),
      .in_ready     (in_ready),
      .result_valid (result_valid),
      .rsp_ch       (rsp_ch)
   );

   // checks
   `SPD_ASSERT_IMPLY(a_write_in_data, clock, reset, store_wr.en, status.frame_state == FS_DATA)
   `SPD_ASSERT_NEXT(a_handled_hunts, clock, reset, accept && (req.op == OP_HANDLED), status.frame_state == FS_HUNT)
   `SPD_ASSERT_IMPLY(a_no_skid_overrun, clock, reset, result_valid && rsp_ch.valid && !rsp_ch.ready, !in_ready)
   `SPD_ASSERT_IMPLY(a_overflow_count, clock, reset, status.overflow, status.data_count == 6'(STORE_DEPTH))

endmodule

`default_nettype wire
